/* design/rmq_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;

   // Default word format: Q1.14 in 16 bits.
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Components are shifted until every magnitude sits below 2^NORM_BITS.
   localparam int NORM_BITS = 30;

   // Which of the four Shepperd branches builds the component vector.
   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

endpackage

/* design/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side payload.
module rmq_sqrt import rmq_pkg::*; #(
   parameter int RW = 20,
   parameter int PW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [PW-1:0]   in_pass,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [PW-1:0]   out_pass
);

   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [PW-1:0]   pass_ff [RW];
   logic [RW-1:0]   vld_ff;

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [RW:0]     rem_prev;
      logic [RW-1:0]   root_prev;
      logic [2*RW-1:0] rad_prev;
      logic [PW-1:0]   pass_prev;
      logic            vld_prev;
      logic [RW+1:0]   rem_sh;
      logic [RW+1:0]   trial;
      logic [RW+1:0]   diff;
      logic            ge;
      logic [RW:0]     rem_in;
      logic [RW-1:0]   root_in;

      // The first stage starts from the incoming word, later ones from the stage before.
      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign pass_prev = in_pass;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign pass_prev = pass_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign rem_sh  = {rem_prev[RW-1:0], rad_prev[2*RW-1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign diff    = rem_sh - trial;
      assign ge      = (rem_sh >= trial);
      assign rem_in  = ge ? diff[RW:0] : rem_sh[RW:0];
      assign root_in = {root_prev[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         rad_ff[s]  <= rad_prev << 2;
         pass_ff[s] <= pass_prev;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pass  = pass_ff[RW-1];

endmodule

/* design/rmq_div.sv */
// Pipelined restoring divider for one lane, one quotient bit per stage.
module rmq_div import rmq_pkg::*; #(
   parameter int RW = 20,
   parameter int QW = 15,
   parameter int PW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [RW+QW-1:0] in_num,
   input  logic [RW-1:0]    in_den,
   input  logic [PW-1:0]    in_pass,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo,
   output logic [PW-1:0]    out_pass
);

   logic [RW-1:0] rem_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [RW-1:0] den_ff  [QW];
   logic [PW-1:0] pass_ff [QW];
   logic [QW-1:0] vld_ff;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [RW-1:0] rem_prev;
      logic [QW-1:0] quo_prev;
      logic [QW-1:0] low_prev;
      logic [RW-1:0] den_prev;
      logic [PW-1:0] pass_prev;
      logic          vld_prev;
      logic [RW:0]   rem_sh;
      logic [RW:0]   diff;
      logic          ge;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      // The high part of the numerator is already below the divisor.
      if (s == 0) begin : g_first
         assign rem_prev  = in_num[RW+QW-1:QW];
         assign quo_prev  = '0;
         assign low_prev  = in_num[QW-1:0];
         assign den_prev  = in_den;
         assign pass_prev = in_pass;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign low_prev  = low_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign pass_prev = pass_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      // Shift in the next numerator bit and subtract when it fits.
      assign rem_sh = {rem_prev, low_prev[QW-1]};
      assign diff   = rem_sh - {1'b0, den_prev};
      assign ge     = (rem_sh >= {1'b0, den_prev});
      assign rem_in = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      assign quo_in = {quo_prev[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         quo_ff[s]  <= quo_in;
         low_ff[s]  <= low_prev << 1;
         den_ff[s]  <= den_prev;
         pass_ff[s] <= pass_prev;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_pass  = pass_ff[QW-1];

endmodule

/* design/rotation_matrix_to_quaternion_top.sv */
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//   channel  ports                         handshake
//   request  req_r0c0 .. req_r2c2          start, busy (busy stays low)
//   result   rsp_quat_x .. rsp_degenerate  rsp_valid, one cycle, no back pressure
//
// One matrix word is taken every cycle. RW is the square root width (one stage per root
// bit) and QW = FRAC_BITS + 1 is the quotient width (one divider stage per bit).
// Reset clears only the valid bits of the pipeline. Nothing stalls, since the
// receiver takes every result word in the cycle it is shown.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_r0c0,
   input  logic signed [DATA_WIDTH-1:0] req_r0c1,
   input  logic signed [DATA_WIDTH-1:0] req_r0c2,
   input  logic signed [DATA_WIDTH-1:0] req_r1c0,
   input  logic signed [DATA_WIDTH-1:0] req_r1c1,
   input  logic signed [DATA_WIDTH-1:0] req_r1c2,
   input  logic signed [DATA_WIDTH-1:0] req_r2c0,
   input  logic signed [DATA_WIDTH-1:0] req_r2c1,
   input  logic signed [DATA_WIDTH-1:0] req_r2c2,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   output logic                         rsp_degenerate
);

   localparam int DW   = DATA_WIDTH;
   localparam int FB   = FRAC_BITS;
   // Component width: sums of three elements plus one.
   localparam int CW   = ((DW > FB + 1) ? DW : FB + 1) + 3;
   localparam int MW   = (CW > NORM_BITS) ? NORM_BITS : CW;
   localparam int KMAX = (CW > NORM_BITS) ? CW - NORM_BITS : 0;
   localparam int KW   = $clog2(KMAX + 2);
   localparam int RW   = MW + 1;
   localparam int SW   = 2 * RW;
   localparam int QW   = FB + 1;
   localparam int NW   = RW + QW;
   localparam int XW   = ((QW > DW) ? QW : DW) + 1;
   localparam int PW   = 1 + 4 + 4 * MW;

   localparam logic signed [CW-1:0] ONE_C  = {{(CW-1){1'b0}}, 1'b1} << FB;
   localparam logic [DW-1:0]        HI_D   = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0]        LO_D   = {1'b1, {(DW-1){1'b0}}};
   localparam logic [XW-1:0]        HI_X   = XW'(HI_D);
   localparam logic [XW-1:0]        LO_X   = HI_X + XW'(1);
   localparam logic [DW-1:0]        IDENT_W = (FB >= DW - 1) ? HI_D
                                              : ({{(DW-1){1'b0}}, 1'b1} << FB);

   // Signs a quotient and saturates it to the output range.
   function automatic logic [DW-1:0] sat_out(input logic [QW-1:0] q, input logic neg);
      logic [XW-1:0] qx;
      logic [XW-1:0] nx;
      qx = XW'(q);
      nx = XW'(0) - qx;
      if (neg) begin
         sat_out = (qx > LO_X) ? LO_D : nx[DW-1:0];
      end else begin
         sat_out = (qx > HI_X) ? HI_D : qx[DW-1:0];
      end
   endfunction

   // Every word moves on each cycle, so a new one is always welcome.
   assign busy = 1'b0;

   // Stage 1: capture the matrix.
   logic signed [DW-1:0] req_e [9];
   logic signed [DW-1:0] p1_e_ff [9];
   logic                 p1_vld_ff;

   assign req_e[0] = req_r0c0;
   assign req_e[1] = req_r0c1;
   assign req_e[2] = req_r0c2;
   assign req_e[3] = req_r1c0;
   assign req_e[4] = req_r1c1;
   assign req_e[5] = req_r1c2;
   assign req_e[6] = req_r2c0;
   assign req_e[7] = req_r2c1;
   assign req_e[8] = req_r2c2;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      p1_e_ff <= req_e;
   end

   // Stage 2: trace test and choice of the largest diagonal element.
   logic signed [DW+1:0] p1_trace;
   branch_type           p2_branch_in;
   branch_type           p2_branch_ff;
   logic signed [DW-1:0] p2_e_ff [9];
   logic                 p2_vld_ff;

   assign p1_trace = (DW+2)'(p1_e_ff[0]) + (DW+2)'(p1_e_ff[4]) + (DW+2)'(p1_e_ff[8]);

   always_comb begin
      priority if (p1_trace > 0) begin
         p2_branch_in = BR_TRACE;
      end else if (p1_e_ff[0] > p1_e_ff[4] && p1_e_ff[0] > p1_e_ff[8]) begin
         p2_branch_in = BR_X;
      end else if (p1_e_ff[4] > p1_e_ff[8]) begin
         p2_branch_in = BR_Y;
      end else begin
         p2_branch_in = BR_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_e_ff      <= p1_e_ff;
      p2_branch_ff <= p2_branch_in;
   end

   // Stage 3: build the integer component vector of the chosen branch.
   logic signed [CW-1:0] x_e [9];
   logic signed [CW-1:0] p3_c_in [4];
   logic signed [CW-1:0] p3_rad;
   logic signed [CW-1:0] p3_c_ff [4];
   logic                 p3_bad_ff;
   logic                 p3_vld_ff;

   for (genvar i = 0; i < 9; i++) begin : g_ext
      assign x_e[i] = CW'(p2_e_ff[i]);
   end

   always_comb begin
      unique case (p2_branch_ff)
         BR_TRACE: begin
            p3_rad     = ONE_C;
            p3_c_in[0] = x_e[7] - x_e[5];
            p3_c_in[1] = x_e[2] - x_e[6];
            p3_c_in[2] = x_e[3] - x_e[1];
            p3_c_in[3] = ONE_C + x_e[0] + x_e[4] + x_e[8];
         end
         BR_X: begin
            p3_rad     = ONE_C + x_e[0] - x_e[4] - x_e[8];
            p3_c_in[0] = p3_rad;
            p3_c_in[1] = x_e[1] + x_e[3];
            p3_c_in[2] = x_e[2] + x_e[6];
            p3_c_in[3] = x_e[7] - x_e[5];
         end
         BR_Y: begin
            p3_rad     = ONE_C + x_e[4] - x_e[0] - x_e[8];
            p3_c_in[0] = x_e[1] + x_e[3];
            p3_c_in[1] = p3_rad;
            p3_c_in[2] = x_e[5] + x_e[7];
            p3_c_in[3] = x_e[2] - x_e[6];
         end
         BR_Z: begin
            p3_rad     = ONE_C + x_e[8] - x_e[0] - x_e[4];
            p3_c_in[0] = x_e[2] + x_e[6];
            p3_c_in[1] = x_e[5] + x_e[7];
            p3_c_in[2] = p3_rad;
            p3_c_in[3] = x_e[3] - x_e[1];
         end
         default: begin
            p3_rad     = ONE_C;
            p3_c_in[0] = '0;
            p3_c_in[1] = '0;
            p3_c_in[2] = '0;
            p3_c_in[3] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_c_ff   <= p3_c_in;
      p3_bad_ff <= (p3_rad <= 0);
   end

   // Stage 4: split into sign and magnitude, and find the largest magnitude.
   logic [CW-1:0] p4_mag_in [4];
   logic [3:0]    p4_neg_in;
   logic [CW-1:0] p4_max01;
   logic [CW-1:0] p4_max23;
   logic [CW-1:0] p4_mag_ff [4];
   logic [3:0]    p4_neg_ff;
   logic [CW-1:0] p4_max_ff;
   logic          p4_bad_ff;
   logic          p4_vld_ff;

   for (genvar i = 0; i < 4; i++) begin : g_abs
      assign p4_neg_in[i] = p3_c_ff[i][CW-1];
      assign p4_mag_in[i] = p4_neg_in[i] ? CW'(-p3_c_ff[i]) : CW'(p3_c_ff[i]);
   end

   assign p4_max01 = (p4_mag_in[0] > p4_mag_in[1]) ? p4_mag_in[0] : p4_mag_in[1];
   assign p4_max23 = (p4_mag_in[2] > p4_mag_in[3]) ? p4_mag_in[2] : p4_mag_in[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_mag_ff <= p4_mag_in;
      p4_neg_ff <= p4_neg_in;
      p4_max_ff <= (p4_max01 > p4_max23) ? p4_max01 : p4_max23;
      p4_bad_ff <= p3_bad_ff;
   end

   // Stage 5: shift every magnitude right until all fit the norm range.
   logic [KW-1:0] p5_k;
   logic [CW-1:0] p5_sh [4];
   logic [MW-1:0] p5_mag_ff [4];
   logic [3:0]    p5_neg_ff;
   logic          p5_bad_ff;
   logic          p5_vld_ff;

   always_comb begin
      p5_k = KW'(KMAX);
      for (int j = KMAX; j >= 0; j--) begin
         if (((p4_max_ff >> j) >> NORM_BITS) == '0) begin
            p5_k = KW'(j);
         end
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_shift
      assign p5_sh[i] = p4_mag_ff[i] >> p5_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else begin
         p5_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         p5_mag_ff[i] <= p5_sh[i][MW-1:0];
      end
      p5_neg_ff <= p4_neg_ff;
      p5_bad_ff <= p4_bad_ff;
   end

   // Stage 6: square each component.
   logic [2*MW-1:0] p6_sq_ff  [4];
   logic [MW-1:0]   p6_mag_ff [4];
   logic [3:0]      p6_neg_ff;
   logic            p6_bad_ff;
   logic            p6_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_vld_ff <= 1'b0;
      end else begin
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         p6_sq_ff[i] <= p5_mag_ff[i] * p5_mag_ff[i];
      end
      p6_mag_ff <= p5_mag_ff;
      p6_neg_ff <= p5_neg_ff;
      p6_bad_ff <= p5_bad_ff;
   end

   // Stage 7: sum of squares.
   logic [SW-1:0] p7_sum_ff;
   logic [PW-1:0] p7_pass_ff;
   logic          p7_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
      end else begin
         p7_vld_ff <= p6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p7_sum_ff  <= SW'(p6_sq_ff[0]) + SW'(p6_sq_ff[1]) + SW'(p6_sq_ff[2])
                    + SW'(p6_sq_ff[3]);
      p7_pass_ff <= {p6_bad_ff, p6_neg_ff,
                     p6_mag_ff[3], p6_mag_ff[2], p6_mag_ff[1], p6_mag_ff[0]};
   end

   // Magnitude: floor of the square root of the sum.
   logic          sq_vld;
   logic [RW-1:0] sq_root;
   logic [PW-1:0] sq_pass;

   rmq_sqrt #(
      .RW(RW),
      .PW(PW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p7_vld_ff),
      .in_rad   (p7_sum_ff),
      .in_pass  (p7_pass_ff),
      .out_valid(sq_vld),
      .out_root (sq_root),
      .out_pass (sq_pass)
   );

   // Numerator stage: scale each magnitude and add half the divisor for rounding.
   logic [NW-1:0] nm_num_ff [4];
   logic [RW-1:0] nm_den_ff;
   logic [3:0]    nm_neg_ff;
   logic          nm_bad_ff;
   logic          nm_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff <= 1'b0;
      end else begin
         nm_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         nm_num_ff[i] <= (NW'(sq_pass[i*MW +: MW]) << FB) + NW'(sq_root >> 1);
      end
      nm_den_ff <= sq_root;
      nm_neg_ff <= sq_pass[4*MW +: 4];
      nm_bad_ff <= sq_pass[PW-1] || (sq_root == '0);
   end

   // Four divider lanes; lane 0 also carries the degenerate flag.
   logic [3:0]    dv_vld;
   logic [QW-1:0] dv_quo [4];
   logic [1:0]    dv_pass0;
   logic [2:0]    dv_neg_hi;

   rmq_div #(
      .RW(RW),
      .QW(QW),
      .PW(2)
   ) u_div0 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (nm_vld_ff),
      .in_num   (nm_num_ff[0]),
      .in_den   (nm_den_ff),
      .in_pass  ({nm_bad_ff, nm_neg_ff[0]}),
      .out_valid(dv_vld[0]),
      .out_quo  (dv_quo[0]),
      .out_pass (dv_pass0)
   );

   for (genvar i = 1; i < 4; i++) begin : g_lane
      rmq_div #(
         .RW(RW),
         .QW(QW),
         .PW(1)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_valid (nm_vld_ff),
         .in_num   (nm_num_ff[i]),
         .in_den   (nm_den_ff),
         .in_pass  (nm_neg_ff[i]),
         .out_valid(dv_vld[i]),
         .out_quo  (dv_quo[i]),
         .out_pass (dv_neg_hi[i-1])
      );
   end

   // Output stage: sign, saturate, or give the identity for a degenerate word.
   logic          out_bad;
   logic [DW-1:0] out_q_in [4];

   assign out_bad     = dv_pass0[1];
   assign out_q_in[0] = out_bad ? '0 : sat_out(dv_quo[0], dv_pass0[0]);
   assign out_q_in[1] = out_bad ? '0 : sat_out(dv_quo[1], dv_neg_hi[0]);
   assign out_q_in[2] = out_bad ? '0 : sat_out(dv_quo[2], dv_neg_hi[1]);
   assign out_q_in[3] = out_bad ? IDENT_W : sat_out(dv_quo[3], dv_neg_hi[2]);

   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_q_ff [4];
   logic          rsp_degenerate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= &dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_q_ff          <= out_q_in;
      rsp_degenerate_ff <= out_bad;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_x     = rsp_q_ff[0];
   assign rsp_quat_y     = rsp_q_ff[1];
   assign rsp_quat_z     = rsp_q_ff[2];
   assign rsp_quat_w     = rsp_q_ff[3];
   assign rsp_degenerate = rsp_degenerate_ff;

endmodule

/* design/rmq_checker.sv */
// Port-level checks for the rotation matrix to quaternion block, bound to the top level.
module rmq_checker import rmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic signed [DATA_WIDTH-1:0] req_r0c0,
   input logic signed [DATA_WIDTH-1:0] req_r0c1,
   input logic signed [DATA_WIDTH-1:0] req_r0c2,
   input logic signed [DATA_WIDTH-1:0] req_r1c0,
   input logic signed [DATA_WIDTH-1:0] req_r1c1,
   input logic signed [DATA_WIDTH-1:0] req_r1c2,
   input logic signed [DATA_WIDTH-1:0] req_r2c0,
   input logic signed [DATA_WIDTH-1:0] req_r2c1,
   input logic signed [DATA_WIDTH-1:0] req_r2c2,
   input logic                         rsp_valid,
   input logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   input logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   input logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   input logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   input logic                         rsp_degenerate
);

   // The pipeline takes a word every cycle, so it never reports busy.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised on a fully pipelined block");

   // In the cycle after reset no stale result word may appear.
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // A degenerate word carries the identity: no vector part.
   a_degen_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0)
      else $error("degenerate word with nonzero vector part");

   // A degenerate word never carries a zero scalar part.
   a_degen_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_quat_w != '0)
      else $error("degenerate word with zero scalar part");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_rmq_checker (.*);
